// ----- hdl/sit_pkg.sv -----
// Shared constants for the segment intersection test.
// Parameter defaults, result width and verdict codes; no dependencies.
package sit_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int POINT_W        = 24;

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_POINT   = 2'd1;
    localparam logic [1:0] VERDICT_OVERLAP = 2'd2;

endpackage

// ----- hdl/segment_intersection_test.sv -----
// Top level of the segment intersection test: front pipeline, divider, output register.
// Depends on sit_pkg and sit_div.
//
// Usage:
//   Segment channel: seg_valid/seg_stall with endpoints ax..dy of segments AB and CD.
//   Result channel: res_valid/res_stall with verdict (none, point, overlap) and the
//   point in point_x/point_y with FRAC_BITS fraction bits, zero unless verdict is point.
//   A transaction moves on a rising edge with valid high and stall low.
//   Throughput: one transaction per cycle while res_stall is low.
//   Pipeline: five stages of differences, products, cross and dot sums and decisions,
//   then the divider with one stage per quotient bit plus product and rounding stages,
//   then the output register.
//   Each stage has its own valid bit and loads whenever it is empty or the stage after
//   it loads, so bubbles close up and input is taken while a result waits.
//   When the receiver stalls, the pipeline fills up and seg_stall rises only once
//   every stage holds a transaction; nothing is lost or repeated.
//   Reset clears all valid bits; no clearing pass is needed.
module segment_intersection_test #(
    parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seg_valid,
    output logic                          seg_stall,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by,
    input  logic signed [COORD_BITS-1:0]  cx,
    input  logic signed [COORD_BITS-1:0]  cy,
    input  logic signed [COORD_BITS-1:0]  dx,
    input  logic signed [COORD_BITS-1:0]  dy,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [1:0]                    verdict,
    output logic signed [sit_pkg::POINT_W-1:0] point_x,
    output logic signed [sit_pkg::POINT_W-1:0] point_y
);

    import sit_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int XW    = PW + 1;
    localparam int NUM_W = XW - 1;
    localparam int MW    = CW + FRAC_BITS;
    localparam int PXW   = CW + FRAC_BITS + 2;
    localparam int WW    = (PXW > POINT_W) ? PXW : POINT_W;
    localparam int NPROD = 22;
    localparam int NSUM  = 11;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [DW-1:0] ba_x;
        logic signed [DW-1:0] ba_y;
        logic [3:0]           eq;
    } carry_t;

    typedef struct packed {
        logic [1:0]           verdict;
        logic                 pt_div;
        logic                 pt_b;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [DW-1:0] ba_x;
        logic signed [DW-1:0] ba_y;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

    function automatic logic signed [DW-1:0] sub(input logic signed [CW-1:0] p,
                                                 input logic signed [CW-1:0] q);
        return DW'(p) - DW'(q);
    endfunction

    function automatic logic le0(input logic signed [XW-1:0] v);
        return v[XW-1] || (v == '0);
    endfunction

    logic [5:0] en_f;
    logic [4:0] vld_f_reg;
    logic [4:0] vld_f_next;
    logic       div_stall;
    logic       div_valid;
    logic       en_o;

    assign en_f[5] = !div_stall;
    genvar k;
    generate
        for (k = 0; k < 5; k++) begin : g_en
            assign en_f[k] = !vld_f_reg[k] || en_f[k+1];
        end
    endgenerate

    assign seg_stall  = !en_f[0];
    assign vld_f_next = {vld_f_reg[3:0], seg_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_f_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                if (en_f[i])
                begin
                    vld_f_reg[i] <= vld_f_next[i];
                end
            end
        end
    end

    // stage 1: differences and endpoint matches
    logic signed [DW-1:0] ba_x_reg, ba_y_reg, cd_x_reg, cd_y_reg, ca_x_reg, ca_y_reg;
    logic signed [DW-1:0] da_x_reg, da_y_reg, cb_x_reg, cb_y_reg, db_x_reg, db_y_reg;
    carry_t c1_reg, c2_reg, c3_reg, c4_reg;

    always_ff @(posedge clk)
    begin
        if (en_f[0])
        begin
            ba_x_reg <= sub(bx, ax);
            ba_y_reg <= sub(by, ay);
            cd_x_reg <= sub(cx, dx);
            cd_y_reg <= sub(cy, dy);
            ca_x_reg <= sub(cx, ax);
            ca_y_reg <= sub(cy, ay);
            da_x_reg <= sub(dx, ax);
            da_y_reg <= sub(dy, ay);
            cb_x_reg <= sub(cx, bx);
            cb_y_reg <= sub(cy, by);
            db_x_reg <= sub(dx, bx);
            db_y_reg <= sub(dy, by);
            c1_reg.a_x  <= ax;
            c1_reg.a_y  <= ay;
            c1_reg.ba_x <= sub(bx, ax);
            c1_reg.ba_y <= sub(by, ay);
            c1_reg.eq   <= {(bx == dx) && (by == dy), (bx == cx) && (by == cy),
                            (ax == dx) && (ay == dy), (ax == cx) && (ay == cy)};
        end
    end

    // stage 2: products
    logic signed [DW-1:0] opa [NPROD];
    logic signed [DW-1:0] opb [NPROD];
    logic signed [PW-1:0] prod_reg [NPROD];

    always_comb
    begin
        // cross d, nk, nl
        opa[0]  = ba_x_reg; opb[0]  = cd_y_reg;
        opa[1]  = cd_x_reg; opb[1]  = ba_y_reg;
        opa[2]  = ca_x_reg; opb[2]  = cd_y_reg;
        opa[3]  = cd_x_reg; opb[3]  = ca_y_reg;
        opa[4]  = ba_x_reg; opb[4]  = ca_y_reg;
        opa[5]  = ca_x_reg; opb[5]  = ba_y_reg;
        // shared endpoint dots
        opa[6]  = da_x_reg; opb[6]  = ba_x_reg;
        opa[7]  = da_y_reg; opb[7]  = ba_y_reg;
        opa[8]  = ca_x_reg; opb[8]  = ba_x_reg;
        opa[9]  = ca_y_reg; opb[9]  = ba_y_reg;
        opa[10] = ca_x_reg; opb[10] = cd_x_reg;
        opa[11] = ca_y_reg; opb[11] = cd_y_reg;
        opa[12] = da_x_reg; opb[12] = cd_x_reg;
        opa[13] = da_y_reg; opb[13] = cd_y_reg;
        // containment dots
        opa[14] = ca_x_reg; opb[14] = cb_x_reg;
        opa[15] = ca_y_reg; opb[15] = cb_y_reg;
        opa[16] = da_x_reg; opb[16] = db_x_reg;
        opa[17] = da_y_reg; opb[17] = db_y_reg;
        opa[18] = ca_x_reg; opb[18] = da_x_reg;
        opa[19] = ca_y_reg; opb[19] = da_y_reg;
        opa[20] = cb_x_reg; opb[20] = db_x_reg;
        opa[21] = cb_y_reg; opb[21] = db_y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_f[1])
        begin
            for (int i = 0; i < NPROD; i++)
            begin
                prod_reg[i] <= opa[i] * opb[i];
            end
            c2_reg <= c1_reg;
        end
    end

    // stage 3: cross and dot sums
    logic signed [XW-1:0] sum_reg [NSUM];

    always_ff @(posedge clk)
    begin
        if (en_f[2])
        begin
            for (int i = 0; i < NSUM; i++)
            begin
                if (i < 3)
                begin
                    sum_reg[i] <= XW'(prod_reg[2*i]) - XW'(prod_reg[2*i+1]);
                end
                else
                begin
                    sum_reg[i] <= XW'(prod_reg[2*i]) + XW'(prod_reg[2*i+1]);
                end
            end
            c3_reg <= c2_reg;
        end
    end

    // stage 4: sign normalize and collinear verdict
    logic                 dneg;
    logic                 one_sh;
    logic                 s_ok;
    logic                 contain;
    logic [1:0]           col_verdict;
    logic [2:0]           sh_cnt;
    logic signed [XW-1:0] d_abs_reg, nk_n_reg, nl_n_reg;
    logic                 dz_reg, col_reg, col_pt_b_reg;
    logic [1:0]           col_verdict_reg;

    always_comb
    begin
        dneg   = sum_reg[0][XW-1];
        sh_cnt = 3'(c3_reg.eq[0]) + 3'(c3_reg.eq[1]) + 3'(c3_reg.eq[2]) + 3'(c3_reg.eq[3]);
        one_sh = (sh_cnt == 3'd1);
        if (c3_reg.eq[0])
        begin
            s_ok = le0(sum_reg[3]);
        end
        else if (c3_reg.eq[1])
        begin
            s_ok = le0(sum_reg[4]);
        end
        else if (c3_reg.eq[2])
        begin
            s_ok = le0(sum_reg[5]);
        end
        else
        begin
            s_ok = !sum_reg[6][XW-1];
        end
        contain = le0(sum_reg[7]) || le0(sum_reg[8]) || le0(sum_reg[9]) || le0(sum_reg[10]);
        if (one_sh)
        begin
            col_verdict = s_ok ? VERDICT_POINT : VERDICT_OVERLAP;
        end
        else
        begin
            col_verdict = contain ? VERDICT_OVERLAP : VERDICT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f[3])
        begin
            d_abs_reg       <= dneg ? -sum_reg[0] : sum_reg[0];
            nk_n_reg        <= dneg ? -sum_reg[1] : sum_reg[1];
            nl_n_reg        <= dneg ? -sum_reg[2] : sum_reg[2];
            dz_reg          <= (sum_reg[0] == '0);
            col_reg         <= (sum_reg[1] == '0) && (sum_reg[2] == '0);
            col_verdict_reg <= col_verdict;
            col_pt_b_reg    <= !(c3_reg.eq[0] || c3_reg.eq[1]);
            c4_reg          <= c3_reg;
        end
    end

    // stage 5: range test and divider operands
    logic                 in_range;
    logic [CW-1:0]        abs_x, abs_y;
    logic signed [DW-1:0] neg_x, neg_y;
    side_t                side_next;
    logic [SIDE_W-1:0]    side5_reg;
    logic [NUM_W-1:0]     num5_reg, den5_reg;
    logic [MW-1:0]        mag_x5_reg, mag_y5_reg;

    always_comb
    begin
        in_range = !nk_n_reg[XW-1] && (nk_n_reg <= d_abs_reg)
                && !nl_n_reg[XW-1] && (nl_n_reg <= d_abs_reg);
        neg_x = -c4_reg.ba_x;
        neg_y = -c4_reg.ba_y;
        abs_x = c4_reg.ba_x[DW-1] ? neg_x[CW-1:0] : c4_reg.ba_x[CW-1:0];
        abs_y = c4_reg.ba_y[DW-1] ? neg_y[CW-1:0] : c4_reg.ba_y[CW-1:0];
        if (!dz_reg)
        begin
            side_next.verdict = in_range ? VERDICT_POINT : VERDICT_NONE;
        end
        else if (col_reg)
        begin
            side_next.verdict = col_verdict_reg;
        end
        else
        begin
            side_next.verdict = VERDICT_NONE;
        end
        side_next.pt_div = !dz_reg;
        side_next.pt_b   = col_pt_b_reg;
        side_next.a_x    = c4_reg.a_x;
        side_next.a_y    = c4_reg.a_y;
        side_next.ba_x   = c4_reg.ba_x;
        side_next.ba_y   = c4_reg.ba_y;
    end

    always_ff @(posedge clk)
    begin
        if (en_f[4])
        begin
            side5_reg  <= side_next;
            num5_reg   <= nk_n_reg[NUM_W-1:0];
            den5_reg   <= d_abs_reg[NUM_W-1:0];
            mag_x5_reg <= MW'(abs_x) << FRAC_BITS;
            mag_y5_reg <= MW'(abs_y) << FRAC_BITS;
        end
    end

    logic [MW-1:0]     q_x, q_y;
    logic [SIDE_W-1:0] side_div;

    sit_div #(
        .NUM_W  (NUM_W),
        .MAG_W  (MW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_f_reg[4]),
        .in_stall  (div_stall),
        .num       (num5_reg),
        .den       (den5_reg),
        .mag_x     (mag_x5_reg),
        .mag_y     (mag_y5_reg),
        .side_in   (side5_reg),
        .out_valid (div_valid),
        .out_stall (!en_o),
        .q_x       (q_x),
        .q_y       (q_y),
        .side_out  (side_div)
    );

    // output stage: assemble the point
    side_t                sd;
    logic signed [WW-1:0] ax_w, ay_w, px_w, py_w, offx_w, offy_w;
    logic                 res_valid_reg;
    logic [1:0]           verdict_reg;
    logic signed [POINT_W-1:0] point_x_reg, point_y_reg;

    always_comb
    begin
        sd     = side_t'(side_div);
        ax_w   = WW'(sd.a_x);
        ay_w   = WW'(sd.a_y);
        offx_w = signed'(WW'(q_x));
        offy_w = signed'(WW'(q_y));
        if (sd.verdict != VERDICT_POINT)
        begin
            px_w = '0;
            py_w = '0;
        end
        else if (sd.pt_div)
        begin
            px_w = sd.ba_x[DW-1] ? (ax_w <<< FRAC_BITS) - offx_w : (ax_w <<< FRAC_BITS) + offx_w;
            py_w = sd.ba_y[DW-1] ? (ay_w <<< FRAC_BITS) - offy_w : (ay_w <<< FRAC_BITS) + offy_w;
        end
        else if (sd.pt_b)
        begin
            px_w = (ax_w + WW'(sd.ba_x)) <<< FRAC_BITS;
            py_w = (ay_w + WW'(sd.ba_y)) <<< FRAC_BITS;
        end
        else
        begin
            px_w = ax_w <<< FRAC_BITS;
            py_w = ay_w <<< FRAC_BITS;
        end
    end

    assign en_o = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en_o)
        begin
            res_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_o)
        begin
            verdict_reg <= sd.verdict;
            point_x_reg <= px_w[POINT_W-1:0];
            point_y_reg <= py_w[POINT_W-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign verdict   = verdict_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;

endmodule

// ----- hdl/sit_div.sv -----
// Pipelined two-lane multiply and rounded divide: round(num * mag / den).
// One quotient bit per stage; sideband travels with each transaction.
// No package dependencies.
module sit_div #(
    parameter int NUM_W  = 34,
    parameter int MAG_W  = 24,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [NUM_W-1:0]  num,
    input  logic [NUM_W-1:0]  den,
    input  logic [MAG_W-1:0]  mag_x,
    input  logic [MAG_W-1:0]  mag_y,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [MAG_W-1:0]  q_x,
    output logic [MAG_W-1:0]  q_y,
    output logic [SIDE_W-1:0] side_out
);

    localparam int QW  = MAG_W;
    localparam int NW  = NUM_W + MAG_W;
    localparam int LO  = NUM_W / 2;
    localparam int HI  = NUM_W - LO;
    localparam int NST = QW + 3;

    logic [NST:0]   en;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;

    logic [MAG_W-1:0]     mag [2];
    logic [LO+MAG_W-1:0]  plo_reg [2];
    logic [HI+MAG_W-1:0]  phi_reg [2];
    logic [NUM_W-1:0]     den0_reg;
    logic [SIDE_W-1:0]    side0_reg;

    logic [NW-1:0]     rem_reg  [2][QW+1];
    logic [QW-1:0]     q_reg    [2][QW];
    logic [NUM_W-1:0]  den_reg  [QW+1];
    logic [SIDE_W-1:0] side_reg [QW+1];

    logic [QW-1:0]     qr_reg [2];
    logic [SIDE_W-1:0] side_out_reg;

    assign mag[0] = mag_x;
    assign mag[1] = mag_y;

    assign en[NST] = !out_stall;
    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end
    endgenerate

    assign in_stall = !en[0];
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    // partial products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < 2; l++)
            begin
                plo_reg[l] <= num[LO-1:0] * mag[l];
                phi_reg[l] <= num[NUM_W-1:LO] * mag[l];
            end
            den0_reg  <= den;
            side0_reg <= side_in;
        end
    end

    // full product
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][0] <= (NW'(phi_reg[l]) << LO) + NW'(plo_reg[l]);
            end
            den_reg[0]  <= den0_reg;
            side_reg[0] <= side0_reg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_bit
            localparam int BIT = QW - 1 - j;
            logic [NW-1:0] shifted;
            logic [QW-1:0] q_prev [2];
            logic [QW-1:0] q_next [2];
            logic          ge     [2];

            assign shifted = NW'(den_reg[j]) << BIT;

            always_comb
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if (j == 0)
                    begin
                        q_prev[l] = '0;
                    end
                    else
                    begin
                        q_prev[l] = q_reg[l][(j == 0) ? 0 : j-1];
                    end
                    ge[l]          = rem_reg[l][j] >= shifted;
                    q_next[l]      = q_prev[l];
                    q_next[l][BIT] = ge[l];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[j+2])
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        rem_reg[l][j+1] <= ge[l] ? rem_reg[l][j] - shifted : rem_reg[l][j];
                        q_reg[l][j]     <= q_next[l];
                    end
                    den_reg[j+1]  <= den_reg[j];
                    side_reg[j+1] <= side_reg[j];
                end
            end
        end
    endgenerate

    // round to nearest, ties up
    logic half [2];
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            half[l] = {rem_reg[l][QW][NUM_W-1:0], 1'b0} >= {1'b0, den_reg[QW]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            for (int l = 0; l < 2; l++)
            begin
                qr_reg[l] <= q_reg[l][QW-1] + QW'(half[l]);
            end
            side_out_reg <= side_reg[QW];
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign q_x       = qr_reg[0];
    assign q_y       = qr_reg[1];
    assign side_out  = side_out_reg;

endmodule

// ----- test/segment_intersection_checker.sv -----
// Checker for the segment intersection test: watches both channels, predicts each result
// from the accepted segment pair and compares it field by field. Depends on sit_pkg.
module segment_intersection_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     seg_valid,
    input  logic                     seg_stall,
    input  logic signed [15:0]       ax,
    input  logic signed [15:0]       ay,
    input  logic signed [15:0]       bx,
    input  logic signed [15:0]       by,
    input  logic signed [15:0]       cx,
    input  logic signed [15:0]       cy,
    input  logic signed [15:0]       dx,
    input  logic signed [15:0]       dy,
    input  logic                     res_valid,
    input  logic                     res_stall,
    input  logic [1:0]               verdict,
    input  logic signed [sit_pkg::POINT_W-1:0] point_x,
    input  logic signed [sit_pkg::POINT_W-1:0] point_y,
    output int                       failures,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sit_pkg::*;

    typedef struct packed {
        logic [1:0]               verdict;
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
    } contact_t;

    contact_t expected_contacts[$];

    function automatic longint scale_along(longint a, longint b, longint num, longint den);
        longint delta;
        longint mag;
        longint prod;
        longint off;
        longint rem;
        delta = b - a;
        mag = (delta < 0 ? -delta : delta) * 256;
        prod = num * mag;
        off = prod / den;
        rem = prod - off * den;
        if (rem >= den - rem)
            off = off + 1;
        return delta < 0 ? a * 256 - off : a * 256 + off;
    endfunction

    function automatic longint crs(longint px, longint py, longint qx, longint qy);
        return px * qy - qx * py;
    endfunction

    function automatic longint dt(longint px, longint py, longint qx, longint qy);
        return px * qx + py * qy;
    endfunction

    function automatic contact_t find_contact(longint ax_, longint ay_, longint bx_,
        longint by_, longint cx_, longint cy_, longint dx_, longint dy_);
        contact_t r;
        longint den;
        longint nk;
        longint nl;
        longint s;
        longint qx;
        longint qy;
        bit ac, ad, bc, bd;
        int shared;
        r = '0;
        qx = 0;
        qy = 0;
        den = crs(bx_ - ax_, by_ - ay_, cx_ - dx_, cy_ - dy_);
        nk = crs(cx_ - ax_, cy_ - ay_, cx_ - dx_, cy_ - dy_);
        nl = crs(bx_ - ax_, by_ - ay_, cx_ - ax_, cy_ - ay_);
        if (den != 0)
        begin
            if (den < 0)
            begin
                den = -den;
                nk = -nk;
                nl = -nl;
            end
            if (nk >= 0 && nk <= den && nl >= 0 && nl <= den)
            begin
                r.verdict = VERDICT_POINT;
                qx = scale_along(ax_, bx_, nk, den);
                qy = scale_along(ay_, by_, nk, den);
            end
        end
        else if (nk == 0 && nl == 0)
        begin
            ac = (ax_ == cx_ && ay_ == cy_);
            ad = (ax_ == dx_ && ay_ == dy_);
            bc = (bx_ == cx_ && by_ == cy_);
            bd = (bx_ == dx_ && by_ == dy_);
            shared = ac + ad + bc + bd;
            if (shared == 1)
            begin
                if (ac)
                    s = dt(ax_ - dx_, ay_ - dy_, ax_ - bx_, ay_ - by_);
                else if (ad)
                    s = dt(ax_ - cx_, ay_ - cy_, ax_ - bx_, ay_ - by_);
                else if (bc)
                    s = dt(cx_ - ax_, cy_ - ay_, cx_ - dx_, cy_ - dy_);
                else
                    s = dt(dx_ - ax_, dy_ - ay_, dx_ - cx_, dy_ - cy_);
                if (s <= 0)
                begin
                    r.verdict = VERDICT_POINT;
                    qx = ((ac || ad) ? ax_ : bx_) * 256;
                    qy = ((ac || ad) ? ay_ : by_) * 256;
                end
                else
                    r.verdict = VERDICT_OVERLAP;
            end
            else if (dt(cx_ - ax_, cy_ - ay_, cx_ - bx_, cy_ - by_) <= 0 ||
                     dt(dx_ - ax_, dy_ - ay_, dx_ - bx_, dy_ - by_) <= 0 ||
                     dt(ax_ - cx_, ay_ - cy_, ax_ - dx_, ay_ - dy_) <= 0 ||
                     dt(bx_ - cx_, by_ - cy_, bx_ - dx_, by_ - dy_) <= 0)
                r.verdict = VERDICT_OVERLAP;
        end
        r.px = qx[POINT_W-1:0];
        r.py = qy[POINT_W-1:0];
        return r;
    endfunction

    assign pending = expected_contacts.size();

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        if (!rst_n)
        begin
            failures <= 0;
            expected_contacts.delete();
        end
        else
        begin
            if (seg_valid && !seg_stall)
                expected_contacts.push_back(find_contact(ax, ay, bx, by, cx, cy, dx, dy));
            if (res_valid && !res_stall)
            begin
                if (expected_contacts.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_contacts.pop_front();
                    if (verdict !== want.verdict)
                    begin
                        $error("verdict expected %0d actual %0d", want.verdict, verdict);
                        failures <= failures + 1;
                    end
                    else if (point_x !== want.px || point_y !== want.py)
                    begin
                        if (point_x !== want.px)
                            $error("point_x expected %0d actual %0d", want.px, point_x);
                        if (point_y !== want.py)
                            $error("point_y expected %0d actual %0d", want.py, point_y);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- test/testbench.sv -----
// Top of the segment intersection test bench: clock, reset, stimulus and verdict.
// Depends on sit_pkg, segment_intersection_test and segment_intersection_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sit_pkg::*;

    localparam int WATCHDOG = 5000;
    localparam int HOLD_CYCLES = 200;

    logic clk = 0;
    logic rst_n = 0;
    logic seg_valid = 0;
    logic seg_stall;
    logic signed [15:0] ax = 0, ay = 0, bx = 0, by = 0, cx = 0, cy = 0, dx = 0, dy = 0;
    logic res_valid;
    logic res_stall = 0;
    logic [1:0] verdict;
    logic signed [POINT_W-1:0] point_x, point_y;
    int failures;
    int pending;
    int send_idle = 0;
    int recv_stall = 0;
    bit hold_off = 0;
    int quiet = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    segment_intersection_test dut (.*);
    segment_intersection_checker checker_i (.*);

    always @(posedge clk)
    begin
        if (hold_off)
            res_stall <= 1;
        else
            res_stall <= ($urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        if ((seg_valid && !seg_stall) || (res_valid && !res_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG)
        begin
            $display("segment_intersection_test verification failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] rcoord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(16)) - 8;
            default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    task automatic offer(logic signed [15:0] a0, a1, b0, b1, c0, c1, d0, d1);
        while ($urandom_range(99) < send_idle)
        begin
            seg_valid <= 0;
            @(posedge clk);
        end
        seg_valid <= 1;
        {ax, ay, bx, by, cx, cy, dx, dy} <= {a0, a1, b0, b1, c0, c1, d0, d1};
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
    endtask

    task automatic random_pair();
        int m;
        logic signed [15:0] a0, a1, b0, b1, t0, t1;
        m = $urandom_range(3);
        a0 = rcoord(m == 3 ? 0 : m);
        a1 = rcoord(m == 3 ? 0 : m);
        b0 = rcoord(m == 3 ? 0 : m);
        b1 = rcoord(m == 3 ? 0 : m);
        case ($urandom_range(3))
            0: offer(a0, a1, b0, b1, rcoord(m), rcoord(m), rcoord(m), rcoord(m));
            1:
            begin
                t0 = $signed($urandom_range(6)) - 3;
                t1 = $signed($urandom_range(6)) - 3;
                offer(a0, a1, b0, b1, a0 + t0 * (b0 - a0), a1 + t0 * (b1 - a1),
                      a0 + t1 * (b0 - a0), a1 + t1 * (b1 - a1));
            end
            2: offer(a0, a1, b0, b1, b0, b1, rcoord(m), rcoord(m));
            default: offer(a0, a1, b0, b1, a0 + 1, a1, b0 + 1, b1);
        endcase
    endtask

    task automatic drain();
        seg_valid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        offer(0, 0, 0, 0, 0, 0, 0, 0);
        offer(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        offer(0, 0, 4, 4, 0, 4, 4, 0);
        offer(0, 0, 3, 0, 1, 1, 2, 5);
        offer(0, 0, 4, 0, 4, 0, 8, 0);
        offer(0, 0, 4, 0, 4, 0, 2, 0);
        offer(0, 0, 4, 0, 2, 0, 6, 0);
        offer(0, 0, 4, 0, 5, 0, 8, 0);
        offer(0, 0, 4, 0, 0, 1, 4, 1);
        offer(0, 0, 0, 0, 0, 0, 3, 3);
        offer(1, 1, 1, 1, 1, 1, 1, 1);
        offer(0, 0, 3, 0, 0, 0, 3, 0);
        offer(0, 0, 3, 1, 1, 0, 0, 2);
        offer(-1, -1, -7, -3, -5, 0, -2, -9);
        offer(32767, -32768, -32768, 32767, 0, 0, -1, -1);
        offer(-16, 0, 16, 0, 0, -16, 0, 16);
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            send_idle = (phase == 1 || phase == 4) ? 55 : (phase == 3 ? 10 : 0);
            recv_stall = (phase == 2 || phase == 4) ? 55 : (phase == 3 ? 10 : 0);
            if (phase == 0)
            begin
                fork
                    begin
                        hold_off = 1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int i = 0; i < 270; i++)
            begin
                random_pair();
            end
        end
        drain();
        repeat (60) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("segment_intersection_test verification clean");
        else
            $display("segment_intersection_test verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/sit_pkg.sv
hdl/sit_div.sv
hdl/segment_intersection_test.sv
test/segment_intersection_checker.sv
test/testbench.sv
